// ===== rtl/pile_pkg.sv =====
// pile_pkg: shared constants, command codes and controller/datapath interface structs
// for the packed integer list engine. No dependencies.

package pile_pkg;

	localparam int VALUE_W = 32;
	localparam int CMD_W   = 2;
	localparam int CAP_W   = 7;
	localparam int HIT_W   = 6;
	localparam int FILL_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic start;     // transaction accepted, latch payload and clear the walk
		logic scan_en;   // walk the list comparing against the value
		logic shift_en;  // walk from the hit moving entries down one place
		logic commit;    // update count, do the insert, load the result register
	} pile_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_hit;
		logic scan_end;
		logic shift_end;
		logic is_remove;
		logic out_free;
	} pile_sts_t;

endpackage

// ===== rtl/packed_integer_list_engine.sv =====
// packed_integer_list_engine: top level, joins the controller and the datapath.
// Depends on pile_pkg, pile_ctrl, pile_dp (which holds pile_ram).

// Keeps a packed list of up to DEPTH signed 32-bit integers in a single-port-write
// RAM with a fill count. command 0 appends value if the count is below the
// effective capacity (capacity register clamped to DEPTH), 1 searches for the first
// equal entry, 2 removes the first equal entry and moves later ones down; code 3
// does nothing. Each transaction yields one result with ok, hit_index, fill_count,
// is_full and is_empty. One transaction is in flight at a time. The list walk
// reads one RAM entry per cycle, and the RAM read port sets that pace. Search and
// remove walk the filled part of the list; insert and no-op do not walk it. A
// finished result sits in the output register while the next transaction is
// accepted and worked on. capacity resets to 64 and is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while idle (not enforced by the block).

module packed_integer_list_engine #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pile_pkg::CAP_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pile_pkg::CMD_W-1:0]          command,
	input  logic signed [pile_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [pile_pkg::HIT_W-1:0]          hit_index,
	output logic [pile_pkg::FILL_W-1:0]         fill_count,
	output logic                                is_full,
	output logic                                is_empty
);

	import pile_pkg::*;

	pile_cmd_t ctl_cmd;
	pile_sts_t dp_sts;

	pile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	pile_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl_cmd),
		.sts         (dp_sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.hit_index   (hit_index),
		.fill_count  (fill_count),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

endmodule

// ===== rtl/pile_ram.sv =====
// pile_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module pile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/pile_ctrl.sv =====
// pile_ctrl: sequencing state machine of the packed integer list engine.
// Depends on pile_pkg for the command and status structs and command codes.

module pile_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [pile_pkg::CMD_W-1:0] command,
	output logic                      in_ready,
	input  pile_pkg::pile_sts_t       sts,
	output pile_pkg::pile_cmd_t       cmd
);

	import pile_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.start    = accept;
		cmd.scan_en  = (state_q == ST_SCAN);
		cmd.shift_en = (state_q == ST_SHIFT);
		cmd.commit   = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_SEARCH || command == CMD_REMOVE) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					priority if (sts.scan_hit) begin
						state_q <= sts.is_remove ? ST_SHIFT : ST_DONE;
					end else if (sts.scan_end) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SHIFT: begin
					if (sts.shift_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_commit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (state_q == ST_DONE) && sts.out_free)
		else $error("commit issued outside the result state");
	a_scan_leaves_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_hit && !sts.is_remove) |=> state_q == ST_DONE)
		else $error("search hit did not finish the transaction");
	a_accept_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("controller stayed idle after accepting a transaction");

endmodule

// ===== rtl/pile_dp.sv =====
// pile_dp: list datapath: entry RAM, fill count, capacity register, walk pointer,
// compare stage and result register. Depends on pile_pkg and pile_ram.

module pile_dp #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pile_pkg::pile_cmd_t             cmd,
	output pile_pkg::pile_sts_t             sts,
	input  logic                            cfg_wr_en,
	input  logic [pile_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic [pile_pkg::CMD_W-1:0]      command,
	input  logic signed [pile_pkg::VALUE_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ok,
	output logic [pile_pkg::HIT_W-1:0]      hit_index,
	output logic [pile_pkg::FILL_W-1:0]     fill_count,
	output logic                            is_full,
	output logic                            is_empty
);

	import pile_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]   capacity_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [VALUE_W-1:0] value_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_idx_q;
	logic [AW-1:0]      cmp_idx_s1;
	logic               cmp_vld_s1;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;

	logic [VALUE_W-1:0] rdata;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;

	logic [EW-1:0] cap_eff;
	logic          can_insert;
	logic          walk_more;
	logic          match;
	logic [CW-1:0] count_nx;
	logic          ok_nx;

	// list walk issues one read a cycle; compare or move acts on the read data in the cycle after the read
	assign walk_more = (rd_idx_q < count_q);
	assign match     = cmp_vld_s1 && (rdata == value_q);

	assign cap_eff    = (EW'(capacity_q) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(capacity_q);
	assign can_insert = (EW'(count_q) < cap_eff);

	always_comb begin
		count_nx = count_q;
		ok_nx    = 1'b0;
		unique case (cmd_q)
			CMD_INSERT: begin
				ok_nx = can_insert;
				if (can_insert) begin
					count_nx = count_q + CW'(1);
				end
			end
			CMD_SEARCH: ok_nx = hit_q;
			CMD_REMOVE: begin
				ok_nx = hit_q;
				if (hit_q) begin
					count_nx = count_q - CW'(1);
				end
			end
			default: ok_nx = 1'b0;
		endcase
	end

	// shift writes the entry read last cycle one place lower; insert writes at the tail
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = value_q;
		priority if (cmd.shift_en && cmp_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cmp_idx_s1 - AW'(1);
			ram_wdata = rdata;
		end else if (cmd.commit && cmd_q == CMD_INSERT && can_insert) begin
			ram_we = 1'b1;
		end else begin
			ram_we = 1'b0;
		end
	end

	pile_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		sts           = '0;
		sts.scan_hit  = match;
		sts.scan_end  = !cmp_vld_s1 && !walk_more;
		sts.shift_end = !cmp_vld_s1 && !walk_more;
		sts.is_remove = (cmd_q == CMD_REMOVE);
		sts.out_free  = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end

			if (cmd.start) begin
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else if (cmd.scan_en && match) begin
				// restart the walk just above the hit for a possible shift
				hit_q      <= 1'b1;
				rd_idx_q   <= CW'(cmp_idx_s1) + CW'(1);
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.scan_en || cmd.shift_en) begin
				cmp_vld_s1 <= walk_more;
				if (walk_more) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end

			if (cmd.commit) begin
				count_q   <= count_nx;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q     <= command;
			value_q   <= value;
			hit_idx_q <= '0;
		end else if (cmd.scan_en && match) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if ((cmd.scan_en || cmd.shift_en) && walk_more) begin
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (cmd.commit) begin
			ok         <= ok_nx;
			hit_index  <= hit_q ? HIT_W'(hit_idx_q) : '0;
			fill_count <= FILL_W'(count_nx);
			is_full    <= (EW'(count_nx) >= cap_eff);
			is_empty   <= (count_nx == '0);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");
	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count_q))
		else $error("fill count changed outside a commit");
	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> CW'(cmp_idx_s1) < count_q)
		else $error("walk read beyond the filled part of the list");
	a_shift_only_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_en && cmp_vld_s1) |-> hit_q && (cmd_q == CMD_REMOVE))
		else $error("entry moved without a remove hit");

endmodule
